// File: sv/rwc_pkg.sv
// package: shared types, constants and register codes for the wall column texel pipeline
`timescale 1ns / 1ps
package rwc_pkg;

    // default limits for the top level parameters
    localparam int SCREEN_ROWS_MAX_DEF = 2048;
    localparam int TEX_SIZE_MAX_DEF    = 1024;

    // fixed field widths
    localparam int HW     = 12;     // screen height
    localparam int TEXW   = 11;     // texture size and texel coordinates before output
    localparam int LINEW  = 16;     // line height
    localparam int N1W    = 30;     // line height dividend
    localparam int D1W    = 25;     // line height divisor
    localparam int XPW    = 28;     // texel x product
    localparam int N2W    = 27;     // texel y dividend
    localparam int SW     = 18;     // signed wall start and end

    localparam logic [16:0]      ONE_Q16  = 17'd65536;
    localparam logic [LINEW-1:0] LINE_MAX = 16'hFFFF;

    // register indexes
    localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd0;
    localparam logic [2:0] CFG_TEX_WIDTH     = 3'd1;
    localparam logic [2:0] CFG_TEX_HEIGHT    = 3'd2;
    localparam logic [2:0] CFG_CEILING_RGB   = 3'd3;
    localparam logic [2:0] CFG_FLOOR_RGB     = 3'd4;
    localparam logic [2:0] CFG_MAP_COLS      = 3'd5;
    localparam logic [2:0] CFG_MAP_ROWS      = 3'd6;

    // pixel kinds
    localparam logic [1:0] KIND_CEILING = 2'd0;
    localparam logic [1:0] KIND_WALL    = 2'd1;
    localparam logic [1:0] KIND_FLOOR   = 2'd2;
    localparam logic [1:0] KIND_VOID    = 2'd3;

    // texture faces
    localparam logic [2:0] FACE_N    = 3'd0;
    localparam logic [2:0] FACE_S    = 3'd1;
    localparam logic [2:0] FACE_E    = 3'd2;
    localparam logic [2:0] FACE_W    = 3'd3;
    localparam logic [2:0] FACE_DOOR = 3'd4;

    // work done by one pipeline stage
    typedef enum logic [2:0] {
        OP_TEX,
        OP_DIV1,
        OP_LINE,
        OP_NUM2,
        OP_DIV2,
        OP_OUT
    } t_op;

    // clamped configuration seen by every stage
    typedef struct packed {
        logic [HW-1:0]   h;
        logic [TEXW-1:0] w_m1;
        logic [TEXW-1:0] t_m1;
        logic [23:0]     ceiling_rgb;
        logic [23:0]     floor_rgb;
        logic [8:0]      map_cols;
        logic [8:0]      map_rows;
    } t_cfg;

    // one pixel word as it moves down the pipeline
    typedef struct packed {
        logic [11:0]      column;
        logic [10:0]      row;
        logic             side_is_y;
        logic             dir_negative;
        logic             is_door;
        logic             off_map;
        logic [XPW-1:0]   xprod;
        logic [TEXW-1:0]  tx;
        logic [N1W-1:0]   rem1;
        logic [D1W-1:0]   d1;
        logic             sat;
        logic [LINEW-1:0] q1;
        logic [LINEW-1:0] line;
        logic [1:0]       kind;
        logic [LINEW-1:0] rs;
        logic [N2W-1:0]   rem2;
        logic [TEXW-1:0]  q2;
        logic [2:0]       face;
        logic [TEXW-1:0]  ty;
        logic [23:0]      rgb;
    } t_item;

endpackage

// File: sv/rwc_front.sv
// entry logic: door offset, texel x product and line height dividend
`timescale 1ns / 1ps
module rwc_front (
    input  rwc_pkg::t_cfg  i_cfg,
    input  logic [11:0]    i_column,
    input  logic [10:0]    i_row,
    input  logic [23:0]    i_distance,
    input  logic [15:0]    i_wall_pos,
    input  logic           i_side_is_y,
    input  logic           i_dir_negative,
    input  logic           i_is_door,
    input  logic [16:0]    i_door_closed,
    input  logic [7:0]     i_tile_x,
    input  logic [7:0]     i_tile_y,
    output rwc_pkg::t_item o_item
);
    import rwc_pkg::*;

    logic [16:0] closed;
    logic [16:0] open_amt;
    logic [16:0] x_frac;

    // texel x fraction: door shifted by its opening, plain faces reversed
    always_comb begin
        closed   = (i_door_closed > ONE_Q16) ? ONE_Q16 : i_door_closed;
        open_amt = ONE_Q16 - closed;
        if (i_is_door) begin
            x_frac = {1'b0, i_wall_pos} + open_amt;
        end else begin
            x_frac = ONE_Q16 - {1'b0, i_wall_pos};
        end
    end

    // build the word
    always_comb begin
        o_item              = '0;
        o_item.column       = i_column;
        o_item.row          = i_row;
        o_item.side_is_y    = i_side_is_y;
        o_item.dir_negative = i_dir_negative;
        o_item.is_door      = i_is_door;
        o_item.off_map      = ({1'b0, i_tile_x} >= i_cfg.map_cols) ||
                              ({1'b0, i_tile_y} >= i_cfg.map_rows);
        o_item.xprod        = XPW'(x_frac) * XPW'(i_cfg.w_m1);
        o_item.rem1         = {1'b0, i_cfg.h, 17'd0} + N1W'(i_distance);
        o_item.d1           = {i_distance, 1'b0};
    end

endmodule

// File: sv/rwc_stage.sv
// one pipeline stage: a register slot with valid and one step of the work
`timescale 1ns / 1ps
module rwc_stage #(
    parameter rwc_pkg::t_op OP = rwc_pkg::OP_TEX,
    parameter int           K  = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rwc_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    output logic           o_ready,
    input  rwc_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output rwc_pkg::t_item o_item
);
    import rwc_pkg::*;

    logic           r_valid;
    t_item          r_item;
    t_item          n_item;
    logic           en;
    logic [12:0]    txr;
    logic [TEXW-1:0] txs;
    logic [39:0]    dsh1;
    logic [N2W-1:0] dsh2;
    logic [HW-1:0]  hh;
    logic signed [SW-1:0] start_row;
    logic signed [SW-1:0] end_row;
    logic signed [SW-1:0] row_s;

    // stage moves when empty or when the next stage takes its word
    assign en      = !r_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // step of work for this stage
    always_comb begin
        n_item    = i_item;
        txr       = '0;
        txs       = '0;
        dsh1      = '0;
        dsh2      = '0;
        hh        = '0;
        start_row = '0;
        end_row   = '0;
        row_s     = '0;
        case (OP)
            OP_TEX: begin
                // round texel x, saturate, mirror faces N and E
                txr = 13'((29'(i_item.xprod) + 29'd32768) >> 16);
                txs = (txr > 13'(i_cfg.w_m1)) ? i_cfg.w_m1 : txr[TEXW-1:0];
                if (!i_item.is_door && (i_item.side_is_y == i_item.dir_negative)) begin
                    txs = i_cfg.w_m1 - txs;
                end
                n_item.tx  = txs;
                // quotient at or over 65536 saturates, zero distance included
                n_item.sat = D1W'(i_item.rem1[N1W-1:16]) >= i_item.d1;
            end
            OP_DIV1: begin
                // one restoring bit of the line height
                dsh1 = 40'(i_item.d1) << K;
                if (!i_item.sat && (40'(i_item.rem1) >= dsh1)) begin
                    n_item.rem1  = i_item.rem1 - N1W'(dsh1);
                    n_item.q1[K] = 1'b1;
                end
            end
            OP_LINE: begin
                // wall start and end rows, pixel kind
                n_item.line = i_item.sat ? LINE_MAX : i_item.q1;
                hh          = {1'b0, i_cfg.h[HW-1:1]};
                start_row   = $signed(SW'(hh)) - $signed(SW'(n_item.line[LINEW-1:1]));
                end_row     = $signed(SW'(hh)) + $signed(SW'(n_item.line[LINEW-1:1]));
                row_s       = $signed(SW'(i_item.row));
                if (row_s < start_row) begin
                    n_item.kind = KIND_CEILING;
                end else if (row_s >= end_row) begin
                    n_item.kind = KIND_FLOOR;
                end else if (i_item.off_map) begin
                    n_item.kind = KIND_VOID;
                end else begin
                    n_item.kind = KIND_WALL;
                end
                n_item.rs = LINEW'(row_s - start_row);
            end
            OP_NUM2: begin
                // texel y dividend
                n_item.rem2 = N2W'(i_cfg.t_m1) * N2W'(i_item.rs);
            end
            OP_DIV2: begin
                // one restoring bit of the texel row
                dsh2 = N2W'(i_item.line) << K;
                if (i_item.rem2 >= dsh2) begin
                    n_item.rem2  = i_item.rem2 - dsh2;
                    n_item.q2[K] = 1'b1;
                end
            end
            OP_OUT: begin
                // result fields
                n_item.face = FACE_N;
                n_item.tx   = '0;
                n_item.ty   = '0;
                n_item.rgb  = '0;
                case (i_item.kind)
                    KIND_CEILING: n_item.rgb = i_cfg.ceiling_rgb;
                    KIND_FLOOR:   n_item.rgb = i_cfg.floor_rgb;
                    KIND_WALL: begin
                        n_item.tx = i_item.tx;
                        n_item.ty = (i_item.q2 > i_cfg.t_m1) ? i_cfg.t_m1 : i_item.q2;
                        if (i_item.is_door) begin
                            n_item.face = FACE_DOOR;
                        end else if (i_item.side_is_y) begin
                            n_item.face = i_item.dir_negative ? FACE_N : FACE_S;
                        end else begin
                            n_item.face = i_item.dir_negative ? FACE_W : FACE_E;
                        end
                    end
                    default: n_item.rgb = '0;
                endcase
            end
            default: n_item = i_item;
        endcase
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

// File: sv/raycast_wall_column_texel_address.sv
// top level: configuration registers and the texel address pipeline
//
//  port group     direction  handshake                 moves
//  i_in_*/fields  in         i_in_valid / o_in_ready   one pixel word with its ray hit
//  o_out_*/o_*    out        o_out_valid / i_out_ready one classified pixel word
//  i_cfg_*        in         i_cfg_wr_en               register index and data
//
// one word enters per cycle while o_in_ready is high; the pipeline depth is
// set by the 16 line height divide steps and the texel row divide steps.
// reset is synchronous and active low; it empties the pipeline and loads register defaults.
// each stage holds its word while the next one is full, so a stall at the output
// backs up only as far as there are full stages; bubbles fill in behind it.
`timescale 1ns / 1ps
module raycast_wall_column_texel_address #(
    parameter int MAX_SCREEN_ROWS = rwc_pkg::SCREEN_ROWS_MAX_DEF,
    parameter int MAX_TEX_SIZE    = rwc_pkg::TEX_SIZE_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_addr,
    input  logic [23:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [11:0] i_column,
    input  logic [10:0] i_row,
    input  logic [23:0] i_distance,
    input  logic [15:0] i_wall_pos,
    input  logic        i_side_is_y,
    input  logic        i_dir_negative,
    input  logic        i_is_door,
    input  logic [16:0] i_door_closed,
    input  logic [7:0]  i_tile_x,
    input  logic [7:0]  i_tile_y,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [11:0] o_pixel_column,
    output logic [10:0] o_pixel_row,
    output logic [1:0]  o_kind,
    output logic [2:0]  o_face,
    output logic [9:0]  o_texel_x,
    output logic [9:0]  o_texel_y,
    output logic [23:0] o_flat_rgb
);
    import rwc_pkg::*;

    localparam int H_CAP  = (MAX_SCREEN_ROWS > 4095) ? 4095 : MAX_SCREEN_ROWS;
    localparam int T_CAP  = (MAX_TEX_SIZE > 2047) ? 2047 : MAX_TEX_SIZE;
    localparam int TW     = $clog2(T_CAP);
    localparam int NSTAGE = 20 + TW;

    logic [11:0] r_screen_height;
    logic [10:0] r_tex_width;
    logic [10:0] r_tex_height;
    logic [23:0] r_ceiling_rgb;
    logic [23:0] r_floor_rgb;
    logic [8:0]  r_map_cols;
    logic [8:0]  r_map_rows;

    t_cfg  cfg;
    t_item front_item;
    logic  v   [NSTAGE+1];
    logic  rdy [NSTAGE+1];
    t_item itm [NSTAGE+1];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_height <= 12'd480;
            r_tex_width     <= 11'd64;
            r_tex_height    <= 11'd64;
            r_ceiling_rgb   <= '0;
            r_floor_rgb     <= '0;
            r_map_cols      <= 9'd24;
            r_map_rows      <= 9'd24;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_wdata[11:0];
                CFG_TEX_WIDTH:     r_tex_width     <= i_cfg_wdata[10:0];
                CFG_TEX_HEIGHT:    r_tex_height    <= i_cfg_wdata[10:0];
                CFG_CEILING_RGB:   r_ceiling_rgb   <= i_cfg_wdata;
                CFG_FLOOR_RGB:     r_floor_rgb     <= i_cfg_wdata;
                CFG_MAP_COLS:      r_map_cols      <= i_cfg_wdata[8:0];
                CFG_MAP_ROWS:      r_map_rows      <= i_cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    // clamped sizes
    always_comb begin
        cfg             = '0;
        if (r_screen_height == '0) begin
            cfg.h = 12'd1;
        end else if (r_screen_height > 12'(H_CAP)) begin
            cfg.h = 12'(H_CAP);
        end else begin
            cfg.h = r_screen_height;
        end
        if (r_tex_width == '0) begin
            cfg.w_m1 = '0;
        end else if (r_tex_width > 11'(T_CAP)) begin
            cfg.w_m1 = 11'(T_CAP - 1);
        end else begin
            cfg.w_m1 = r_tex_width - 11'd1;
        end
        if (r_tex_height == '0) begin
            cfg.t_m1 = '0;
        end else if (r_tex_height > 11'(T_CAP)) begin
            cfg.t_m1 = 11'(T_CAP - 1);
        end else begin
            cfg.t_m1 = r_tex_height - 11'd1;
        end
        cfg.ceiling_rgb = r_ceiling_rgb;
        cfg.floor_rgb   = r_floor_rgb;
        cfg.map_cols    = r_map_cols;
        cfg.map_rows    = r_map_rows;
    end

    rwc_front u_front (
        .i_cfg          (cfg),
        .i_column       (i_column),
        .i_row          (i_row),
        .i_distance     (i_distance),
        .i_wall_pos     (i_wall_pos),
        .i_side_is_y    (i_side_is_y),
        .i_dir_negative (i_dir_negative),
        .i_is_door      (i_is_door),
        .i_door_closed  (i_door_closed),
        .i_tile_x       (i_tile_x),
        .i_tile_y       (i_tile_y),
        .o_item         (front_item)
    );

    assign v[0]        = i_in_valid;
    assign itm[0]      = front_item;
    assign o_in_ready  = rdy[0];
    assign rdy[NSTAGE] = i_out_ready;

    // stage chain: texel x, 16 line bits, line, product, texel row bits, output
    for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
        localparam t_op SOP = (s == 0)           ? OP_TEX  :
                              (s <= 16)          ? OP_DIV1 :
                              (s == 17)          ? OP_LINE :
                              (s == 18)          ? OP_NUM2 :
                              (s <= 18 + TW)     ? OP_DIV2 : OP_OUT;
        localparam int SK   = (s >= 1 && s <= 16)      ? 16 - s :
                              (s >= 19 && s <= 18 + TW) ? 18 + TW - s : 0;
        rwc_stage #(
            .OP (SOP),
            .K  (SK)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (cfg),
            .i_valid (v[s]),
            .o_ready (rdy[s]),
            .i_item  (itm[s]),
            .o_valid (v[s+1]),
            .i_ready (rdy[s+1]),
            .o_item  (itm[s+1])
        );
    end

    // result ports
    assign o_out_valid    = v[NSTAGE];
    assign o_pixel_column = itm[NSTAGE].column;
    assign o_pixel_row    = itm[NSTAGE].row;
    assign o_kind         = itm[NSTAGE].kind;
    assign o_face         = itm[NSTAGE].face;
    assign o_texel_x      = itm[NSTAGE].tx[9:0];
    assign o_texel_y      = itm[NSTAGE].ty[9:0];
    assign o_flat_rgb     = itm[NSTAGE].rgb;

    // non-wall words carry no texel and no face
    a_nonwall_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind != KIND_WALL) |->
            (o_face == FACE_N) && (o_texel_x == '0) && (o_texel_y == '0))
        else $error("non-wall word with texel or face");

    // wall and void words carry no flat color
    a_wall_no_rgb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_kind == KIND_WALL) || (o_kind == KIND_VOID)) |->
            (o_flat_rgb == '0))
        else $error("wall word with flat color");

    // texel row stays inside the texture
    a_ty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_WALL) |->
            (11'(o_texel_y) <= cfg.t_m1) || (cfg.t_m1 > 11'd1023))
        else $error("texel row beyond texture");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule
